/* rtl/diff_drive_odometry_integrator_assert.svh */
// Assertion macros for the odometry integrator.
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_ASSERT_SVH

`ifndef SYNTH
`define DDO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ddo assertion failed");
`define DDO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddo assertion failed");
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddo assertion failed");
`else
`define DDO_ASSERT(lbl, clk, rst_n, prop)
`define DDO_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ddo_pkg.sv */
package ddo_pkg;

  localparam int LIN_W  = 24;
  localparam int ANG_W  = 24;
  localparam int DT_W   = 16;
  localparam int POS_W  = 32;
  localparam int HEAD_W = 16;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;

  // CORDIC datapath width, Q2.30 plus growth headroom
  localparam int CW         = 34;
  localparam int ATAN_COUNT = 24;
  localparam int ATAN_IW    = 5;

  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_TURN,
    OP_HEAD,
    OP_INIT,
    OP_ROT,
    OP_FIX,
    OP_MUL_X,
    OP_RND_X,
    OP_ACC_X,
    OP_MUL_Y,
    OP_RND_Y,
    OP_ACC_Y,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic rot_last;
  } status_t;

  // arctangents in units of 2^-32 turn
  function automatic logic [31:0] atan_turn32(input logic [ATAN_IW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/ddo_if.sv */
interface ddo_in_if import ddo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LIN_W-1:0] linear_speed;
  logic signed [ANG_W-1:0] angular_speed;
  logic        [DT_W-1:0]  time_step;

  modport source(output valid, output linear_speed, output angular_speed,
                 output time_step, input ready);
  modport sink(input valid, input linear_speed, input angular_speed,
               input time_step, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pose_x;
  logic signed [POS_W-1:0]  pose_y;
  logic signed [HEAD_W-1:0] pose_heading;

  modport source(output valid, output pose_x, output pose_y,
                 output pose_heading, input ready);
  modport sink(input valid, input pose_x, input pose_y,
               input pose_heading, output ready);
endinterface

/* rtl/ddo_ctrl.sv */
module ddo_ctrl import ddo_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    out_ready,
  input  status_t st,
  output logic    in_ready,
  output logic    out_valid,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TURN,
    S_HEAD,
    S_INIT,
    S_ROT,
    S_FIX,
    S_MULX,
    S_RNDX,
    S_ACCX,
    S_MULY,
    S_RNDY,
    S_ACCY,
    S_OUT
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   load_ok;
  logic   take;

  assign load_ok   = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready_r;
  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE:  cmd.op = take ? OP_CAPTURE : OP_NONE;
      S_TURN:  cmd.op = OP_TURN;
      S_HEAD:  cmd.op = OP_HEAD;
      S_INIT:  cmd.op = OP_INIT;
      S_ROT:   cmd.op = OP_ROT;
      S_FIX:   cmd.op = OP_FIX;
      S_MULX:  cmd.op = OP_MUL_X;
      S_RNDX:  cmd.op = OP_RND_X;
      S_ACCX:  cmd.op = OP_ACC_X;
      S_MULY:  cmd.op = OP_MUL_Y;
      S_RNDY:  cmd.op = OP_RND_Y;
      S_ACCY:  cmd.op = OP_ACC_Y;
      S_OUT:   cmd.op = load_ok ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT a taken result is replaced by the new load below
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            state_r    <= S_TURN;
            in_ready_r <= 1'b0;
          end
        end
        S_TURN: state_r <= S_HEAD;
        S_HEAD: state_r <= S_INIT;
        S_INIT: state_r <= S_ROT;
        S_ROT: begin
          if (st.rot_last) begin
            state_r <= S_FIX;
          end
        end
        S_FIX:  state_r <= S_MULX;
        S_MULX: state_r <= S_RNDX;
        S_RNDX: state_r <= S_ACCX;
        S_ACCX: state_r <= S_MULY;
        S_MULY: state_r <= S_RNDY;
        S_RNDY: state_r <= S_ACCY;
        S_ACCY: state_r <= S_OUT;
        S_OUT: begin
          if (load_ok) begin
            out_valid_r <= 1'b1;
            in_ready_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/ddo_datapath.sv */
module ddo_datapath import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  st,
  input  logic signed [LIN_W-1:0]  linear_speed,
  input  logic signed [ANG_W-1:0]  angular_speed,
  input  logic        [DT_W-1:0]   time_step,
  output logic signed [POS_W-1:0]  pose_x,
  output logic signed [POS_W-1:0]  pose_y,
  output logic signed [HEAD_W-1:0] pose_heading
);

  localparam int IW     = $clog2(CORDIC_STEPS);
  localparam int TP_W   = LIN_W + DT_W + 1;
  localparam int PROD_W = LIN_W + POS_W;
  localparam int DX_W   = PROD_W - 30;

  localparam logic signed [PROD_W-1:0] HALF_Q30 = PROD_W'(1) <<< 29;
  localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};

  logic signed [LIN_W-1:0]  v_r, v_nxt;
  logic signed [ANG_W-1:0]  w_r, w_nxt;
  logic        [DT_W-1:0]   dt_r, dt_nxt;
  logic [ANGLE_BITS-1:0]    dangle_r, dangle_nxt;
  logic signed [LIN_W-1:0]  dist_r, dist_nxt;
  logic [ANGLE_BITS-1:0]    heading_r, heading_nxt;
  logic signed [CW-1:0]     x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                     flip_r, flip_nxt;
  logic [IW-1:0]            iter_r, iter_nxt;
  logic signed [POS_W-1:0]  c_r, c_nxt, s_r, s_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DX_W-1:0]   dx_r, dx_nxt;
  logic signed [POS_W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic signed [POS_W-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [HEAD_W-1:0] oh_r, oh_nxt;

  logic signed [TP_W-1:0]   tprod, vprod;
  logic [31:0]              ang, ang_f;
  logic                     flip_c;
  logic signed [CW-1:0]     xs, ys, at;
  logic signed [POS_W-1:0]  mop;
  logic signed [PROD_W-1:0] rsum;
  logic signed [POS_W:0]    acc_sum;
  logic signed [POS_W-1:0]  acc_in, acc_sat;
  logic [ANGLE_BITS+15:0]   hwide;

  assign st.rot_last = (iter_r == IW'(CORDIC_STEPS - 1));

  always_comb begin
    tprod   = w_r * $signed({1'b0, dt_r});
    vprod   = v_r * $signed({1'b0, dt_r});
    ang     = 32'(heading_r) << (32 - ANGLE_BITS);
    flip_c  = ang[31] ^ ang[30];
    ang_f   = flip_c ? {~ang[31], ang[30:0]} : ang;
    xs      = x_r >>> iter_r;
    ys      = y_r >>> iter_r;
    at      = $signed(CW'(atan_turn32(ATAN_IW'(iter_r))));
    mop     = (cmd.op == OP_MUL_Y) ? s_r : c_r;
    rsum    = prod_r + HALF_Q30;
    acc_in  = (cmd.op == OP_ACC_Y) ? py_r : px_r;
    acc_sum = (POS_W+1)'(acc_in) + (POS_W+1)'(dx_r);
    if (acc_sum[POS_W] != acc_sum[POS_W-1]) begin
      acc_sat = acc_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      acc_sat = acc_sum[POS_W-1:0];
    end
    hwide   = {heading_r, 16'b0} >> ANGLE_BITS;

    v_nxt       = v_r;
    w_nxt       = w_r;
    dt_nxt      = dt_r;
    dangle_nxt  = dangle_r;
    dist_nxt    = dist_r;
    heading_nxt = heading_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    flip_nxt    = flip_r;
    iter_nxt    = iter_r;
    c_nxt       = c_r;
    s_nxt       = s_r;
    prod_nxt    = prod_r;
    dx_nxt      = dx_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    oh_nxt      = oh_r;

    unique case (cmd.op)
      OP_CAPTURE: begin
        v_nxt  = linear_speed;
        w_nxt  = angular_speed;
        dt_nxt = time_step;
      end
      OP_TURN: begin
        dangle_nxt = tprod[31 -: ANGLE_BITS];
        dist_nxt   = vprod[LIN_W+15:16];
      end
      OP_HEAD: heading_nxt = heading_r + dangle_r;
      OP_INIT: begin
        x_nxt    = GAIN_Q30;
        y_nxt    = '0;
        z_nxt    = CW'($signed(ang_f));
        flip_nxt = flip_c;
        iter_nxt = '0;
      end
      OP_ROT: begin
        if (!z_r[CW-1]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end
        iter_nxt = iter_r + IW'(1);
      end
      OP_FIX: begin
        c_nxt = flip_r ? POS_W'(-x_r) : POS_W'(x_r);
        s_nxt = flip_r ? POS_W'(-y_r) : POS_W'(y_r);
      end
      OP_MUL_X, OP_MUL_Y: prod_nxt = dist_r * mop;
      OP_RND_X, OP_RND_Y: dx_nxt = rsum[PROD_W-1:30];
      OP_ACC_X: px_nxt = acc_sat;
      OP_ACC_Y: py_nxt = acc_sat;
      OP_OUT: begin
        ox_nxt = px_r;
        oy_nxt = py_r;
        oh_nxt = hwide[HEAD_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
      px_r      <= '0;
      py_r      <= '0;
      iter_r    <= '0;
    end else begin
      heading_r <= heading_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      iter_r    <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    w_r      <= w_nxt;
    dt_r     <= dt_nxt;
    dangle_r <= dangle_nxt;
    dist_r   <= dist_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    flip_r   <= flip_nxt;
    c_r      <= c_nxt;
    s_r      <= s_nxt;
    prod_r   <= prod_nxt;
    dx_r     <= dx_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oh_r     <= oh_nxt;
  end

  assign pose_x       = ox_r;
  assign pose_y       = oy_r;
  assign pose_heading = oh_r;

endmodule

/* rtl/diff_drive_odometry_integrator.sv */
// Dead-reckoning pose integrator for a differential-drive base. Each transfer
// in carries speed, turn rate and time step; each transfer out returns the
// updated x, y (Q16.16, saturating) and heading (binary angle, wrapping).
// One item is in work at a time, from acceptance until its result is loaded;
// the iterative CORDIC does one rotation per cycle, and one shared multiplier
// forms the x and y deltas in turn. The result sits in an output register; the
// next item is accepted as soon as that register has been loaded, and a result
// that is not taken holds the following one back only at its final load.
`include "diff_drive_odometry_integrator_assert.svh"

module diff_drive_odometry_integrator import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ddo_in_if.sink        in_ch,
  ddo_out_if.source     out_ch
);

  cmd_t    cmd;
  status_t st;
  logic    in_ready;
  logic    out_valid;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .linear_speed  (in_ch.linear_speed),
    .angular_speed (in_ch.angular_speed),
    .time_step     (in_ch.time_step),
    .pose_x        (out_ch.pose_x),
    .pose_y        (out_ch.pose_y),
    .pose_heading  (out_ch.pose_heading)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  `DDO_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_ch.valid && in_ready, !in_ready)
  `DDO_ASSERT_IMP(a_valid_from_load, clk, rst_n, $rose(out_valid), $past(cmd.op == OP_OUT))
  `DDO_ASSERT_NEXT(a_rot_then_fix, clk, rst_n, cmd.op == OP_ROT && st.rot_last, cmd.op == OP_FIX)
  `DDO_ASSERT(a_idle_while_ready, clk, rst_n, !in_ready || cmd.op == OP_NONE || cmd.op == OP_CAPTURE)

endmodule

/* sim/odometry_pose_checker.sv */
`timescale 1ns / 100ps

module odometry_pose_checker import ddo_pkg::*; #(
  parameter int ROT_STEPS  = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ddo_in_if    motion_mon,
  ddo_out_if   pose_mon,
  output int   fail_count,
  output int   backlog
);

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [HEAD_W-1:0] heading;
  } pose_t;

  localparam longint ROT_GAIN  = 64'sd652032874;
  localparam longint HALF_LSB  = 64'sd536870912;
  localparam longint POS_TOP   = 64'sd2147483647;
  localparam longint POS_FLOOR = -64'sd2147483648;
  localparam logic [31:0] HEAD_MASK = 32'((64'd1 << ANGLE_BITS) - 1);

  longint      track_x;
  longint      track_y;
  logic [31:0] track_head;
  pose_t       pose_due[$];

  // arctangent of 2^-i in 2^-32 turn
  function automatic longint arc_turn(input int idx);
    case (idx)
      0:       return 536870912;
      1:       return 316933406;
      2:       return 167458907;
      3:       return 85004756;
      4:       return 42667331;
      5:       return 21354465;
      6:       return 10679838;
      7:       return 5340245;
      8:       return 2670163;
      9:       return 1335087;
      10:      return 667544;
      11:      return 333772;
      12:      return 166886;
      13:      return 83443;
      14:      return 41722;
      15:      return 20861;
      16:      return 10430;
      17:      return 5215;
      18:      return 2608;
      19:      return 1304;
      20:      return 652;
      21:      return 326;
      22:      return 163;
      23:      return 81;
      default: return 0;
    endcase
  endfunction

  function automatic longint pin_range(input longint v);
    if (v > POS_TOP) return POS_TOP;
    if (v < POS_FLOOR) return POS_FLOOR;
    return v;
  endfunction

  function automatic pose_t advance_pose(input logic signed [LIN_W-1:0] spd,
                                         input logic signed [ANG_W-1:0] rate,
                                         input logic [DT_W-1:0] dt);
    longint      turn;
    longint      travel;
    longint      cx;
    longint      cy;
    longint      cz;
    longint      sx;
    longint      sy;
    logic [31:0] ang;
    logic [31:0] probe;
    logic        flip;
    pose_t       p;
    turn = longint'(rate) * longint'(dt);
    track_head = (track_head + 32'(turn >> (32 - ANGLE_BITS))) & HEAD_MASK;

    // rotate the left half plane onto the right one, negate afterwards
    ang   = track_head << (32 - ANGLE_BITS);
    probe = ang + 32'h4000_0000;
    flip  = probe[31];
    if (flip) ang = ang + 32'h8000_0000;
    cz = longint'($signed(ang));
    cx = ROT_GAIN;
    cy = 0;
    for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cz >= 0) begin
        cx = cx - sy;
        cy = cy + sx;
        cz = cz - arc_turn(i);
      end else begin
        cx = cx + sy;
        cy = cy - sx;
        cz = cz + arc_turn(i);
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end

    travel = (longint'(spd) * longint'(dt)) >>> 16;
    track_x = pin_range(track_x + ((travel * cx + HALF_LSB) >>> 30));
    track_y = pin_range(track_y + ((travel * cy + HALF_LSB) >>> 30));

    p.x = track_x[31:0];
    p.y = track_y[31:0];
    p.heading = (ANGLE_BITS >= 16) ? 16'(track_head >> (ANGLE_BITS - 16))
                                   : 16'(track_head << (16 - ANGLE_BITS));
    return p;
  endfunction

  always @(posedge clk) begin : watch
    pose_t want;
    if (!rst_n) begin
      track_x    = 0;
      track_y    = 0;
      track_head = '0;
      pose_due.delete();
    end else begin
      if (motion_mon.valid && motion_mon.ready)
        pose_due.push_back(advance_pose(motion_mon.linear_speed,
                                        motion_mon.angular_speed,
                                        motion_mon.time_step));
      if (pose_mon.valid && pose_mon.ready) begin
        if (pose_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: pose transfer with none due: x=%0d y=%0d hdg=%0d", $realtime,
                     pose_mon.pose_x, pose_mon.pose_y, pose_mon.pose_heading);
          fail_count++;
        end else begin
          want = pose_due.pop_front();
          if (pose_mon.pose_x !== want.x || pose_mon.pose_y !== want.y ||
              pose_mon.pose_heading !== want.heading) begin
            if (fail_count < 10)
              $display("%0t: pose mismatch: exp x=%0d y=%0d hdg=%0d, got x=%0d y=%0d hdg=%0d",
                       $realtime, want.x, want.y, want.heading, pose_mon.pose_x,
                       pose_mon.pose_y, pose_mon.pose_heading);
            fail_count++;
          end
        end
      end
    end
    backlog = pose_due.size();
  end

endmodule

/* sim/tb_diff_drive_odometry_integrator.sv */
`timescale 1ns / 100ps

module tb_diff_drive_odometry_integrator;
  import ddo_pkg::*;

  localparam int ROT_STEPS  = 16;
  localparam int HEAD_BITS  = 16;
  localparam int ITEM_GOAL  = 1900;

  localparam logic signed [LIN_W-1:0] LIN_TOP    = 24'sh7FFFFF;
  localparam logic signed [LIN_W-1:0] LIN_BOTTOM = 24'sh800000;
  localparam logic signed [ANG_W-1:0] ANG_TOP    = 24'sh7FFFFF;
  localparam logic signed [ANG_W-1:0] ANG_BOTTOM = 24'sh800000;
  localparam logic [DT_W-1:0]         DT_TOP     = 16'hFFFF;
  localparam logic [DT_W-1:0]         DT_HALF    = 16'h8000;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;
  typedef enum int {MIX_RANDOM, MIX_EXTREME, MIX_STILL, MIX_GENTLE, MIX_BOUNDARY} mix_t;

  logic        clk = 1'b0;
  logic        rst_n;
  int          miss_total;
  int          pose_backlog;
  int          burst_left;
  int          sent;
  int          ready_tick;
  logic [15:0] head_now;

  ddo_in_if  motion_if();
  ddo_out_if pose_if();

  diff_drive_odometry_integrator #(
    .CORDIC_STEPS (ROT_STEPS),
    .ANGLE_BITS   (HEAD_BITS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (motion_if),
    .out_ch (pose_if)
  );

  odometry_pose_checker #(
    .ROT_STEPS  (ROT_STEPS),
    .ANGLE_BITS (HEAD_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .motion_mon (motion_if),
    .pose_mon   (pose_if),
    .fail_count (miss_total),
    .backlog    (pose_backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pose_if.ready <= 1'b0;
      ready_tick    <= 0;
    end else begin
      ready_tick <= ready_tick + 1;
      case (rx_mode_t'((ready_tick / 300) % 4))
        RX_OPEN:  pose_if.ready <= 1'b1;
        RX_LIGHT: pose_if.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: pose_if.ready <= ($urandom_range(0, 3) == 0);
        default:  pose_if.ready <= ((ready_tick % 37) >= 26);
      endcase
    end
  end

  task automatic send_motion(input logic signed [LIN_W-1:0] spd,
                             input logic signed [ANG_W-1:0] rate,
                             input logic [DT_W-1:0] dt);
    int     gap;
    logic   took;
    longint turn;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        motion_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    motion_if.valid         <= 1'b1;
    motion_if.linear_speed  <= spd;
    motion_if.angular_speed <= rate;
    motion_if.time_step     <= dt;
    do begin
      @(negedge clk);
      took = motion_if.ready;
      @(posedge clk);
    end while (!took);
    turn = longint'(rate) * longint'(dt);
    head_now += turn[31:16];
    sent++;
  endtask

  // half-second step: the rate's bits 16:1 become the heading increment
  task automatic turn_to(input logic [15:0] target, input logic signed [LIN_W-1:0] spd);
    logic [15:0] delta;
    delta = target - head_now;
    send_motion(spd, {7'b0, delta, 1'b0}, DT_HALF);
  endtask

  task automatic wait_drained();
    motion_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pose_backlog != 0);
    @(posedge clk);
  endtask

  function automatic logic [23:0] extreme_pick();
    case ($urandom_range(0, 5))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      4:       return 24'h000001;
      default: return 24'($urandom());
    endcase
  endfunction

  // straight run near full speed, long enough to drive x and y into saturation
  task automatic dash(input logic [15:0] target, input int steps);
    int r;
    turn_to(target + 16'($urandom_range(0, 64)) - 16'd32, 24'sd0);
    repeat (steps) begin
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) - 1 : 0;
      send_motion(LIN_TOP - 24'($urandom_range(0, 300000)), 24'(r),
                  DT_TOP - 16'($urandom_range(0, 2000)));
    end
  endtask

  task automatic wander(input int count);
    mix_t        kind;
    logic [15:0] mark;
    repeat (count) begin
      kind = mix_t'($urandom_range(0, 4));
      if ($urandom_range(0, 2) == 0) kind = MIX_RANDOM;
      case (kind)
        MIX_RANDOM:
          send_motion(24'($urandom()), 24'($urandom()), 16'($urandom()));
        MIX_EXTREME:
          case ($urandom_range(0, 3))
            0:       send_motion(extreme_pick(), extreme_pick(), 16'd0);
            1:       send_motion(extreme_pick(), extreme_pick(), 16'd1);
            2:       send_motion(extreme_pick(), extreme_pick(), DT_TOP);
            default: send_motion(extreme_pick(), extreme_pick(), 16'($urandom()));
          endcase
        MIX_STILL:
          send_motion(24'($urandom()), 24'($urandom()), 16'd0);
        MIX_GENTLE:
          send_motion(24'($urandom_range(0, 2097151)) - 24'sd1048576,
                      24'($urandom_range(0, 131071)) - 24'sd65536,
                      16'($urandom_range(0, 4000)));
        default: begin
          mark = 16'($urandom_range(0, 3)) * 16'h4000 + 16'($urandom_range(0, 2)) - 16'd1;
          turn_to(mark, 24'($urandom()));
        end
      endcase
    end
  endtask

  initial begin
    rst_n                   = 1'b0;
    motion_if.valid         = 1'b0;
    motion_if.linear_speed  = '0;
    motion_if.angular_speed = '0;
    motion_if.time_step     = '0;
    pose_if.ready           = 1'b0;
    burst_left              = 0;
    sent                    = 0;
    head_now                = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_motion(24'sd0, 24'sd0, 16'd0);
    send_motion(LIN_TOP, 24'sd0, DT_TOP);
    send_motion(LIN_BOTTOM, 24'sd0, DT_TOP);
    send_motion(24'sd0, ANG_TOP, DT_TOP);
    send_motion(LIN_TOP, ANG_BOTTOM, DT_TOP);
    send_motion(LIN_TOP, ANG_TOP, 16'd0);
    send_motion(24'sd1, 24'sd1, 16'd1);
    send_motion(-24'sd1, -24'sd1, 16'd1);
    send_motion(-24'sd1, -24'sd1, DT_TOP);
    // headings on either side of each quadrant boundary
    for (int k = 0; k < 8; k++)
      turn_to(16'(k / 2) * 16'h4000 - ((k % 2 == 0) ? 16'd1 : 16'd0),
              (k % 2 == 1) ? LIN_TOP : LIN_BOTTOM);
    wait_drained();

    wander(300);
    dash(16'h2000, 440);
    wait_drained();
    wander(250);
    dash(16'hA000, 800);
    if (sent < ITEM_GOAL) wander(ITEM_GOAL - sent);

    motion_if.valid <= 1'b0;
    do @(negedge clk); while (pose_backlog != 0);
    repeat (40) @(posedge clk);
    if (miss_total == 0 && pose_backlog == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
